/* design/multi_alarm_scheduler_core_assert.svh */
// Assertion macros shared by the scheduler core.
`ifndef MULTI_ALARM_SCHEDULER_CORE_ASSERT_SVH
`define MULTI_ALARM_SCHEDULER_CORE_ASSERT_SVH

// The property must hold at every edge outside reset.
`define MAS_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("multi_alarm_scheduler_core: invariant violated");

// The consequent must hold in the same cycle as the antecedent.
`define MAS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("multi_alarm_scheduler_core: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define MAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("multi_alarm_scheduler_core: sequence violated");

`endif

/* design/mas_pkg.sv */
package mas_pkg;

   localparam int MAS_NUM_ALARMS = 4;
   localparam int ENTRY_ID_W = 4;

   localparam int SECS_PER_DAY = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MINUTE = 60;
   localparam int DAYS_PER_WEEK = 7;
   localparam int RESET_HOUR_BASE = 6;

   localparam logic [2:0] SUNDAY = 3'd0;
   localparam logic [2:0] SATURDAY = 3'd6;

   localparam logic [1:0] MODE_ONCE = 2'd0;
   localparam logic [1:0] MODE_WEEKDAYS = 2'd2;

   localparam logic [17:0] COUNT_MAX = 18'h3ffff;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_WRITE,
      KIND_ENABLE,
      KIND_STOP
   } kind_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] entry_index;
      logic [4:0] alarm_hour;
      logic [5:0] alarm_minute;
      logic [1:0] repeat_mode;
      logic       enable;
      logic [2:0] now_weekday;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [5:0] now_second;
   } req_payload_type;

   typedef struct packed {
      logic        pending_valid;
      logic [1:0]  pending_index;
      logic [17:0] seconds_left;
      logic        alerting;
      logic [1:0]  alerting_index;
      logic        fired_now;
   } rsp_payload_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [1:0] mode;
      logic       enable;
   } entry_type;

   function automatic entry_type entry_reset(input logic [ENTRY_ID_W-1:0] idx);
      entry_type e;
      e.hour = 5'(5'(RESET_HOUR_BASE) + 5'(idx));
      e.minute = '0;
      e.mode = MODE_WEEKDAYS;
      e.enable = 1'b0;
      return e;
   endfunction

   function automatic logic [16:0] time_of_day(input logic [4:0] hour,
                                               input logic [5:0] minute,
                                               input logic [5:0] second);
      return 17'(17'(hour) * 17'(SECS_PER_HOUR)) + 17'(17'(minute) * 17'(SECS_PER_MINUTE))
             + 17'(second);
   endfunction

endpackage

/* design/mas_if.sv */
interface mas_req_if import mas_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface mas_rsp_if import mas_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/mas_ram.sv */
module mas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/multi_alarm_scheduler_core.sv */
// Alarm scheduler with a small table of alarms held in a one-port-read RAM.
// Requests arrive on req_bus as valid/ready transactions; each carries the
// current weekday and time plus a command: second tick, write an entry's
// time and mode, set an entry's enable, or stop the alert. Every request
// yields exactly one response transaction on rsp_bus with the schedule and
// alert status after the command has been applied.
// A tick goes from acceptance straight to ST_EMIT, where its response is loaded; an entry
// write, and an enable that leaves the bit unchanged, pass through ST_LOOKUP first.
// Changing an enable or stopping the alert reads the addressed entry and writes
// it back when the enable changes or a stopped once-only alarm is disabled, then
// rescans the whole table one entry per cycle through the RAM read port and a
// two-stage distance pipeline. One request is in flight at a time; the next
// request can be taken in the same cycle as its predecessor's response first sits
// in the output register.
// When the receiver stalls, the response holds in the output register and
// a finished request waits for it to drain before its response is loaded.
// A synchronous reset returns the table to its default contents at once
// through per-entry valid bits, clears the schedule and the alert, and
// leaves no response pending.
`include "multi_alarm_scheduler_core_assert.svh"

module multi_alarm_scheduler_core import mas_pkg::*; #(
   parameter int NUM_ALARMS = MAS_NUM_ALARMS
) (
   input  logic      clock,
   input  logic      reset,
   mas_req_if.sink   req_bus,
   mas_rsp_if.source rsp_bus
);

   localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int CNT_W = $clog2(NUM_ALARMS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic sched_ff, sched_in;
   logic [1:0] sched_entry_ff, sched_entry_in;
   logic [17:0] countdown_ff, countdown_in;
   logic alert_ff, alert_in;
   logic [1:0] alert_entry_ff, alert_entry_in;
   logic fired_ff, fired_in;
   logic [NUM_ALARMS-1:0] valid_ff, valid_in;

   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic s1_valid_ff, s1_valid_in;
   logic cand_valid_ff, cand_valid_in;
   logic found_ff, found_in;

   req_payload_type item_ff;
   logic [2:0] weekday_ff, weekday_in;
   logic [16:0] now_secs_ff;
   logic [IDX_W-1:0] target_ff, target_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;
   logic cand_ok_ff, cand_ok_in;
   logic [18:0] cand_dist_ff, cand_dist_in;
   logic [IDX_W-1:0] cand_idx_ff;
   logic [18:0] best_ff, best_in;
   logic [IDX_W-1:0] pick_ff, pick_in;
   logic item_load;

   logic ram_wr_en;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type ram_wr_data;
   logic [$bits(entry_type)-1:0] ram_rd_data;

   entry_type lookup_entry;
   entry_type scan_entry;
   logic late;
   logic [2:0] next_wd;
   logic [1:0] days;
   logic [18:0] day_secs;
   logic [16:0] entry_secs;
   logic signed [19:0] distance;
   logic issue;
   logic [17:0] tick_count;

   mas_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(NUM_ALARMS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(target_ff),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign lookup_entry = valid_ff[target_ff] ? entry_type'(ram_rd_data)
                                             : entry_reset(ENTRY_ID_W'(target_ff));
   assign scan_entry = valid_ff[s1_idx_ff] ? entry_type'(ram_rd_data)
                                           : entry_reset(ENTRY_ID_W'(s1_idx_ff));

   always_comb begin
      late = (scan_entry.hour < item_ff.now_hour)
             || ((scan_entry.hour == item_ff.now_hour)
                 && (scan_entry.minute <= item_ff.now_minute));
      next_wd = weekday_ff + {2'b00, late};
      if (next_wd == 3'(DAYS_PER_WEEK)) begin
         next_wd = SUNDAY;
      end
      days = {1'b0, late};
      if (scan_entry.mode == MODE_WEEKDAYS) begin
         if (next_wd == SUNDAY) begin
            days = days + 2'd1;
         end else if (next_wd == SATURDAY) begin
            days = days + 2'd2;
         end
      end
      day_secs = 19'(19'(days) * 19'(SECS_PER_DAY));
      entry_secs = time_of_day(scan_entry.hour, scan_entry.minute, 6'd0);
      distance = $signed(20'(day_secs)) + $signed(20'(entry_secs))
                 - $signed(20'(now_secs_ff));
      cand_ok_in = s1_valid_ff && scan_entry.enable && !distance[19] && (distance != '0);
      cand_dist_in = distance[18:0];
   end

   assign tick_count = (countdown_ff != '0) ? (countdown_ff - 18'd1) : countdown_ff;
   assign issue = (rd_cnt_ff < CNT_W'(NUM_ALARMS));

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in = rsp_ff;
      sched_in = sched_ff;
      sched_entry_in = sched_entry_ff;
      countdown_in = countdown_ff;
      alert_in = alert_ff;
      alert_entry_in = alert_entry_ff;
      fired_in = fired_ff;
      valid_in = valid_ff;
      rd_cnt_in = rd_cnt_ff;
      s1_valid_in = 1'b0;
      cand_valid_in = 1'b0;
      found_in = found_ff;
      best_in = best_ff;
      pick_in = pick_ff;
      s1_idx_in = rd_cnt_ff[IDX_W-1:0];
      item_load = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_data = lookup_entry;
      ram_rd_addr = rd_cnt_ff[IDX_W-1:0];
      if (kind_type'(req_bus.payload.kind) == KIND_STOP) begin
         target_in = IDX_W'(alert_entry_ff);
      end else begin
         target_in = IDX_W'(req_bus.payload.entry_index);
      end
      case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = target_in;
            if (req_bus.valid) begin
               item_load = 1'b1;
               fired_in = 1'b0;
               rd_cnt_in = '0;
               found_in = 1'b0;
               case (kind_type'(req_bus.payload.kind))
                  KIND_TICK: begin
                     state_in = ST_EMIT;
                     if (sched_ff) begin
                        countdown_in = tick_count;
                        if (tick_count == '0) begin
                           alert_in = 1'b1;
                           alert_entry_in = sched_entry_ff;
                           sched_in = 1'b0;
                           sched_entry_in = '0;
                           fired_in = 1'b1;
                        end
                     end
                  end
                  KIND_WRITE, KIND_ENABLE: begin
                     if (int'(req_bus.payload.entry_index) < NUM_ALARMS) begin
                        state_in = ST_LOOKUP;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  KIND_STOP: begin
                     alert_in = 1'b0;
                     if (int'(alert_entry_ff) < NUM_ALARMS) begin
                        state_in = ST_LOOKUP;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            case (kind_type'(item_ff.kind))
               KIND_WRITE: begin
                  ram_wr_en = 1'b1;
                  ram_wr_data.hour = item_ff.alarm_hour;
                  ram_wr_data.minute = item_ff.alarm_minute;
                  ram_wr_data.mode = item_ff.repeat_mode;
                  state_in = ST_EMIT;
               end
               KIND_ENABLE: begin
                  if (lookup_entry.enable != item_ff.enable) begin
                     ram_wr_en = 1'b1;
                     ram_wr_data.enable = item_ff.enable;
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
               KIND_STOP: begin
                  if (lookup_entry.mode == MODE_ONCE) begin
                     ram_wr_en = 1'b1;
                     ram_wr_data.enable = 1'b0;
                  end
                  state_in = ST_SCAN;
               end
               default: begin
                  state_in = ST_EMIT;
               end
            endcase
            if (ram_wr_en) begin
               valid_in[target_ff] = 1'b1;
            end
         end
         ST_SCAN: begin
            s1_valid_in = issue;
            rd_cnt_in = rd_cnt_ff + CNT_W'(issue);
            cand_valid_in = s1_valid_ff;
            if (cand_valid_ff && cand_ok_ff && (!found_ff || (cand_dist_ff < best_ff))) begin
               found_in = 1'b1;
               best_in = cand_dist_ff;
               pick_in = cand_idx_ff;
            end
            if (!issue && !s1_valid_ff && !cand_valid_ff) begin
               state_in = ST_EMIT;
               if (found_ff) begin
                  sched_in = 1'b1;
                  sched_entry_in = 2'(pick_ff);
                  countdown_in = (best_ff > 19'(COUNT_MAX)) ? COUNT_MAX : best_ff[17:0];
               end else begin
                  sched_in = 1'b0;
                  sched_entry_in = '0;
                  countdown_in = '0;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.pending_valid = sched_ff;
               rsp_in.pending_index = sched_entry_ff;
               rsp_in.seconds_left = countdown_ff;
               rsp_in.alerting = alert_ff;
               rsp_in.alerting_index = alert_entry_ff;
               rsp_in.fired_now = fired_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      weekday_in = req_bus.payload.now_weekday;
      if (weekday_in == 3'(DAYS_PER_WEEK)) begin
         weekday_in = SUNDAY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sched_ff <= 1'b0;
         sched_entry_ff <= '0;
         countdown_ff <= '0;
         alert_ff <= 1'b0;
         alert_entry_ff <= '0;
         fired_ff <= 1'b0;
         valid_ff <= '0;
         rd_cnt_ff <= '0;
         s1_valid_ff <= 1'b0;
         cand_valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff <= rsp_in;
         sched_ff <= sched_in;
         sched_entry_ff <= sched_entry_in;
         countdown_ff <= countdown_in;
         alert_ff <= alert_in;
         alert_entry_ff <= alert_entry_in;
         fired_ff <= fired_in;
         valid_ff <= valid_in;
         rd_cnt_ff <= rd_cnt_in;
         s1_valid_ff <= s1_valid_in;
         cand_valid_ff <= cand_valid_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_load) begin
         item_ff <= req_bus.payload;
         weekday_ff <= weekday_in;
         now_secs_ff <= time_of_day(req_bus.payload.now_hour, req_bus.payload.now_minute,
                                    req_bus.payload.now_second);
         target_ff <= target_in;
      end
      s1_idx_ff <= s1_idx_in;
      cand_ok_ff <= cand_ok_in;
      cand_dist_ff <= cand_dist_in;
      cand_idx_ff <= s1_idx_ff;
      best_ff <= best_in;
      pick_ff <= pick_in;
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   `MAS_ASSERT_IMPLY(a_pending_counts, clock, reset, sched_ff, countdown_ff != '0)
   `MAS_ASSERT_IMPLY(a_idle_clear, clock, reset, !sched_ff, (countdown_ff == '0) && (sched_entry_ff == '0))
   `MAS_ASSERT_IMPLY(a_fire_alerts, clock, reset, rsp_valid_ff && rsp_ff.fired_now, rsp_ff.alerting)
   `MAS_ASSERT_NEXT(a_accept_busy, clock, reset, req_bus.valid && req_bus.ready, state_ff != ST_IDLE)
   `MAS_ASSERT_ALWAYS(a_scan_no_write, clock, reset, !((state_ff == ST_SCAN) && ram_wr_en))

endmodule

/* tb/multi_alarm_scheduler_core_test.sv */
`timescale 1ns / 100ps

module multi_alarm_scheduler_core_test;
   import mas_pkg::*;

   localparam logic [1:0] MODE_DAILY = 2'd1;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int SETTLE_CYCLES = 20;

   class alarm_schedule_tracker;
      logic [4:0]  hours [MAS_NUM_ALARMS];
      logic [5:0]  minutes [MAS_NUM_ALARMS];
      logic [1:0]  modes [MAS_NUM_ALARMS];
      logic        enables [MAS_NUM_ALARMS];
      logic        sched_flag;
      logic [1:0]  sched_entry;
      logic [17:0] countdown;
      logic        alert_flag;
      logic [1:0]  alert_entry;
      rsp_payload_type expected_status_q[$];
      int mismatches;
      int checked;
      int fires;
      int saturations;
      int reschedules;

      function new();
         for (int i = 0; i < MAS_NUM_ALARMS; i++) begin
            hours[i] = 5'(RESET_HOUR_BASE + i);
            minutes[i] = '0;
            modes[i] = MODE_WEEKDAYS;
            enables[i] = 1'b0;
         end
         sched_flag = 1'b0;
         sched_entry = '0;
         countdown = '0;
         alert_flag = 1'b0;
         alert_entry = '0;
         mismatches = 0;
         checked = 0;
         fires = 0;
         saturations = 0;
         reschedules = 0;
      endfunction

      function void find_next_alarm(req_payload_type r);
         int now_s, hr, mn, wday, h, m, days, wd, gap, best;
         bit found;
         logic [1:0] pick;
         hr = r.now_hour;
         mn = r.now_minute;
         now_s = hr * SECS_PER_HOUR + mn * SECS_PER_MINUTE + int'(r.now_second);
         wday = int'(r.now_weekday) % DAYS_PER_WEEK;
         found = 1'b0;
         best = 0;
         pick = '0;
         reschedules++;
         for (int i = 0; i < MAS_NUM_ALARMS; i++) begin
            if (!enables[i]) continue;
            h = hours[i];
            m = minutes[i];
            days = (h < hr || (h == hr && m <= mn)) ? 1 : 0;
            wd = (wday + days) % DAYS_PER_WEEK;
            if (modes[i] == MODE_WEEKDAYS) begin
               if (wd == SUNDAY) days += 1;
               else if (wd == SATURDAY) days += 2;
            end
            gap = days * SECS_PER_DAY + h * SECS_PER_HOUR + m * SECS_PER_MINUTE - now_s;
            if (gap > 0 && (!found || gap < best)) begin
               best = gap;
               pick = 2'(i);
               found = 1'b1;
            end
         end
         sched_flag = found;
         sched_entry = found ? pick : 2'd0;
         if (!found) countdown = '0;
         else if (best > int'(COUNT_MAX)) begin
            countdown = COUNT_MAX;
            saturations++;
         end else countdown = 18'(best);
      endfunction

      function void apply_command(req_payload_type r);
         rsp_payload_type e;
         logic fired;
         fired = 1'b0;
         case (kind_type'(r.kind))
            KIND_TICK: begin
               if (sched_flag) begin
                  if (countdown > 0) countdown--;
                  if (countdown == 0) begin
                     alert_flag = 1'b1;
                     alert_entry = sched_entry;
                     sched_flag = 1'b0;
                     sched_entry = '0;
                     fired = 1'b1;
                     fires++;
                  end
               end
            end
            KIND_WRITE: begin
               hours[r.entry_index] = r.alarm_hour;
               minutes[r.entry_index] = r.alarm_minute;
               modes[r.entry_index] = r.repeat_mode;
            end
            KIND_ENABLE: begin
               if (enables[r.entry_index] != r.enable) begin
                  enables[r.entry_index] = r.enable;
                  find_next_alarm(r);
               end
            end
            default: begin
               alert_flag = 1'b0;
               if (modes[alert_entry] == MODE_ONCE) enables[alert_entry] = 1'b0;
               find_next_alarm(r);
            end
         endcase
         e.pending_valid = sched_flag;
         e.pending_index = sched_entry;
         e.seconds_left = countdown;
         e.alerting = alert_flag;
         e.alerting_index = alert_entry;
         e.fired_now = fired;
         expected_status_q.push_back(e);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_status(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_status_q.size() == 0) begin
            $error("response transaction with no request outstanding");
            mismatches++;
            return;
         end
         want = expected_status_q.pop_front();
         checked++;
         compare_field("pending_valid", want.pending_valid, got.pending_valid);
         compare_field("pending_index", want.pending_index, got.pending_index);
         compare_field("seconds_left", want.seconds_left, got.seconds_left);
         compare_field("alerting", want.alerting, got.alerting);
         compare_field("alerting_index", want.alerting_index, got.alerting_index);
         compare_field("fired_now", want.fired_now, got.fired_now);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit steady;
   int sent;
   logic [2:0] wall_wday;
   logic [4:0] wall_hour;
   logic [5:0] wall_minute;
   logic [5:0] wall_second;
   alarm_schedule_tracker sb;

   mas_req_if req_bus();
   mas_rsp_if rsp_bus();

   multi_alarm_scheduler_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(input req_payload_type p);
      if (!steady) begin
         while ($urandom_range(99) < 25) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.payload <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.apply_command(p);
      sent++;
   endtask

   task automatic issue(input kind_type k, input logic [1:0] idx, input logic [4:0] ah,
                        input logic [5:0] am, input logic [1:0] mode, input logic en);
      req_payload_type p;
      p.kind = k;
      p.entry_index = idx;
      p.alarm_hour = ah;
      p.alarm_minute = am;
      p.repeat_mode = mode;
      p.enable = en;
      p.now_weekday = wall_wday;
      p.now_hour = wall_hour;
      p.now_minute = wall_minute;
      p.now_second = wall_second;
      send_request(p);
   endtask

   task automatic set_wall_time(input logic [2:0] wd, input logic [4:0] hh,
                                input logic [5:0] mm, input logic [5:0] ss);
      wall_wday = wd;
      wall_hour = hh;
      wall_minute = mm;
      wall_second = ss;
   endtask

   task automatic send_noise();
      req_payload_type p;
      p = req_payload_type'({$urandom, $urandom});
      send_request(p);
   endtask

   task automatic run_alarm_scenario();
      logic [1:0] idx;
      logic [1:0] mode;
      logic [4:0] ah;
      logic [5:0] am;
      int ticks;
      set_wall_time(3'($urandom_range(6)), 5'($urandom_range(23)), 6'($urandom_range(58)),
                    6'($urandom_range(59, 40)));
      idx = 2'($urandom_range(3));
      mode = 2'($urandom_range(3));
      if ($urandom_range(3) == 0) begin
         ah = 5'($urandom_range(23));
         am = 6'($urandom_range(59));
      end else begin
         ah = wall_hour;
         am = wall_minute + 6'd1;
      end
      issue(KIND_WRITE, idx, ah, am, mode, 1'b0);
      if (sb.enables[idx]) issue(KIND_ENABLE, idx, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_ENABLE, idx, 0, 0, MODE_ONCE, 1'b1);
      ticks = 0;
      while (sb.sched_flag && ticks < 25) begin
         issue(KIND_TICK, 2'($urandom_range(3)), 0, 0, MODE_ONCE, 1'b0);
         ticks++;
      end
      if ($urandom_range(4) != 0) issue(KIND_STOP, 0, 0, 0, MODE_ONCE, 1'b0);
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 25);
      end
   end

   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_status(rsp_bus.payload);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) stall = 0;
         else stall++;
      end
      $display("Timed out with %0d responses still expected.", sb.expected_status_q.size());
      $display("multi_alarm_scheduler_core: mismatch");
      $finish;
   end

   initial begin
      int random_sent;
      sb = new();
      steady = 1'b0;
      sent = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.payload <= '0;
      set_wall_time(3'd1, 5'd5, 6'd0, 6'd0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(KIND_TICK, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_STOP, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_ENABLE, 0, 0, 0, MODE_ONCE, 1'b1);
      issue(KIND_ENABLE, 0, 0, 0, MODE_ONCE, 1'b1);
      set_wall_time(3'd6, 5'd0, 6'd0, 6'd0);
      issue(KIND_WRITE, 1, 5'd31, 6'd63, MODE_WEEKDAYS, 1'b0);
      issue(KIND_ENABLE, 1, 0, 0, MODE_ONCE, 1'b1);
      issue(KIND_ENABLE, 0, 0, 0, MODE_ONCE, 1'b0);
      set_wall_time(3'd7, 5'd31, 6'd63, 6'd63);
      issue(KIND_ENABLE, 0, 0, 0, MODE_ONCE, 1'b1);
      set_wall_time(3'd3, 5'd10, 6'd30, 6'd60);
      issue(KIND_WRITE, 2, 5'd10, 6'd31, MODE_ONCE, 1'b0);
      issue(KIND_WRITE, 3, 5'd10, 6'd31, MODE_SPARE, 1'b0);
      issue(KIND_ENABLE, 2, 0, 0, MODE_ONCE, 1'b1);
      set_wall_time(3'd3, 5'd10, 6'd30, 6'd59);
      issue(KIND_ENABLE, 3, 0, 0, MODE_ONCE, 1'b1);
      issue(KIND_TICK, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_TICK, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_ENABLE, 2, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_TICK, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_STOP, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_ENABLE, 2, 0, 0, MODE_ONCE, 1'b1);
      issue(KIND_TICK, 0, 0, 0, MODE_ONCE, 1'b0);
      issue(KIND_STOP, 0, 0, 0, MODE_ONCE, 1'b0);
      set_wall_time(3'd0, 5'd4, 6'd0, 6'd0);
      issue(KIND_WRITE, 0, 5'd23, 6'd59, MODE_DAILY, 1'b0);
      issue(KIND_ENABLE, 1, 0, 0, MODE_ONCE, 1'b0);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         int start;
         int roll;
         start = sent;
         steady = (random_sent >= 600 && random_sent < 900);
         roll = $urandom_range(99);
         if (roll < 60) run_alarm_scenario();
         else if (roll < 85) send_noise();
         else begin
            set_wall_time(3'($urandom_range(7)), 5'($urandom_range(23)),
                          6'($urandom_range(59)), 6'($urandom_range(59)));
            if ($urandom_range(1) == 0)
               issue(KIND_ENABLE, 2'($urandom_range(3)), 0, 0, MODE_ONCE, 1'($urandom));
            else issue(KIND_STOP, 0, 0, 0, MODE_ONCE, 1'b0);
         end
         random_sent += sent - start;
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (sb.expected_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests and checked %0d responses.", sent, sb.checked);
      $display("Saw %0d alarm firings, %0d reschedules and %0d saturated countdowns.",
               sb.fires, sb.reschedules, sb.saturations);
      if (sb.mismatches == 0) $display("multi_alarm_scheduler_core: match");
      else $display("multi_alarm_scheduler_core: mismatch");
      $finish;
   end

endmodule
